// ----- rtl/core/pnm_hp_pkg.sv -----
// Package for the PNM header parser: character codes, byte classes,
// queue entry type and parse phase encoding.
// No dependencies.
package pnm_hp_pkg;

    localparam int DIM_BITS_DEFAULT    = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int OUT_BITS            = 16;
    localparam int CFG_ADDR_BITS       = 3;
    localparam int CFG_DATA_BITS       = 32;

    // Register word index (paddr[2])
    localparam logic REG_MAX_FIELD = 1'b0;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_HASH,
        CLS_P,
        CLS_DIGIT,
        CLS_OTHER
    } byte_class_t;

    typedef struct packed {
        logic        frame_start;
        logic [7:0]  data_byte;
        byte_class_t cls;
        logic        is_lf;
    } byte_entry_t;

    typedef enum logic [5:0] {
        PH_START  = 6'b000001,
        PH_MAGIC  = 6'b000010,
        PH_WIDTH  = 6'b000100,
        PH_HEIGHT = 6'b001000,
        PH_MAX    = 6'b010000,
        PH_DONE   = 6'b100000
    } parse_phase_t;

endpackage

// ----- rtl/core/pnm_hp_if.sv -----
// Channel interfaces of the PNM header parser: header bytes in, results out.
// Depends on nothing.
interface pnm_hp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface pnm_hp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  magic_char;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] max_value;
    logic        header_bad;

    modport source (output valid, output magic_char, output image_width,
                    output image_height, output max_value, output header_bad,
                    input ready);
    modport sink (input valid, input magic_char, input image_width,
                  input image_height, input max_value, input header_bad,
                  output ready);
endinterface

// ----- rtl/core/pnm_hp_classify.sv -----
// Front end of the PNM header parser: tag each incoming byte with its class.
// Depends on pnm_hp_pkg.
module pnm_hp_classify
(
    input  logic [7:0]               data_byte,
    input  logic                     frame_start,
    output pnm_hp_pkg::byte_entry_t  entry
);

    always_comb
    begin
        entry.frame_start = frame_start;
        entry.data_byte   = data_byte;
        entry.is_lf       = (data_byte == pnm_hp_pkg::CH_LF);
        case (data_byte) inside
            pnm_hp_pkg::CH_SPACE, pnm_hp_pkg::CH_TAB,
            pnm_hp_pkg::CH_CR, pnm_hp_pkg::CH_LF:
                entry.cls = pnm_hp_pkg::CLS_SPACE;
            pnm_hp_pkg::CH_HASH:
                entry.cls = pnm_hp_pkg::CLS_HASH;
            pnm_hp_pkg::CH_P:
                entry.cls = pnm_hp_pkg::CLS_P;
            [pnm_hp_pkg::CH_ZERO:pnm_hp_pkg::CH_NINE]:
                entry.cls = pnm_hp_pkg::CLS_DIGIT;
            default:
                entry.cls = pnm_hp_pkg::CLS_OTHER;
        endcase
    end

endmodule

// ----- rtl/core/pnm_hp_queue.sv -----
// Short FIFO of classified bytes between the front end and the parser.
// Depends on pnm_hp_pkg.
module pnm_hp_queue
#(
    parameter int DEPTH = pnm_hp_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  pnm_hp_pkg::byte_entry_t  push_entry,
    output logic                     full,
    input  logic                     pop,
    output pnm_hp_pkg::byte_entry_t  pop_entry,
    output logic                     empty
);

    localparam int PTR_BITS = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

    pnm_hp_pkg::byte_entry_t slot_mem [DEPTH];

    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_BITS'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/core/pnm_hp_parse.sv -----
// Back end of the PNM header parser: phase machine, decimal accumulate
// and result register. Depends on pnm_hp_pkg and pnm_hp_out_if.
module pnm_hp_parse
#(
    parameter int DIM_BITS = pnm_hp_pkg::DIM_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     max_field_present,
    input  pnm_hp_pkg::byte_entry_t  entry,
    input  logic                     entry_valid,
    output logic                     pop,
    pnm_hp_out_if.source             result_out
);

    localparam int ACC_BITS = DIM_BITS + 4;
    localparam int OB       = pnm_hp_pkg::OUT_BITS;

    pnm_hp_pkg::parse_phase_t phase_reg, phase_next, eff_phase;
    logic                comment_reg, comment_next, eff_comment;
    logic                seen_reg, seen_next, eff_seen;
    logic [DIM_BITS-1:0] accum_reg, accum_next, eff_accum;
    logic [7:0]          magic_reg, magic_next;
    logic [DIM_BITS-1:0] width_reg, width_next;
    logic [DIM_BITS-1:0] height_reg, height_next;
    logic [ACC_BITS-1:0] acc_ext, product;
    logic                overflow, is_space;
    logic                emit, emit_bad;
    logic [DIM_BITS-1:0] max_out;

    logic [DIM_BITS+OB-1:0] width_ext, height_ext, max_ext;

    logic        out_valid_reg;
    logic [7:0]  out_magic_reg;
    logic [OB-1:0] out_width_reg, out_height_reg, out_max_reg;
    logic        out_bad_reg;

    assign pop = entry_valid && (!out_valid_reg || result_out.ready);

    // Frame start restarts the parse at this byte
    assign eff_phase   = entry.frame_start ? pnm_hp_pkg::PH_START : phase_reg;
    assign eff_comment = entry.frame_start ? 1'b0 : comment_reg;
    assign eff_seen    = entry.frame_start ? 1'b0 : seen_reg;
    assign eff_accum   = entry.frame_start ? '0 : accum_reg;

    assign is_space = (entry.cls == pnm_hp_pkg::CLS_SPACE);
    assign acc_ext  = {4'b0000, eff_accum};
    assign product  = (acc_ext << 3) + (acc_ext << 1) + ACC_BITS'(entry.data_byte[3:0]);
    assign overflow = |product[ACC_BITS-1:DIM_BITS];

    always_comb
    begin
        phase_next   = eff_phase;
        comment_next = eff_comment;
        seen_next    = eff_seen;
        accum_next   = eff_accum;
        magic_next   = entry.frame_start ? 8'h00 : magic_reg;
        width_next   = entry.frame_start ? '0 : width_reg;
        height_next  = entry.frame_start ? '0 : height_reg;
        emit         = 1'b0;
        emit_bad     = 1'b0;
        max_out      = '0;
        case (eff_phase)
            pnm_hp_pkg::PH_START:
            begin
                if (eff_comment)
                begin
                    comment_next = !entry.is_lf;
                end
                else
                begin
                    case (entry.cls)
                        pnm_hp_pkg::CLS_SPACE: ;
                        pnm_hp_pkg::CLS_HASH:  comment_next = 1'b1;
                        pnm_hp_pkg::CLS_P:     phase_next = pnm_hp_pkg::PH_MAGIC;
                        default:
                        begin
                            emit     = 1'b1;
                            emit_bad = 1'b1;
                        end
                    endcase
                end
            end
            pnm_hp_pkg::PH_MAGIC:
            begin
                magic_next = entry.data_byte;
                phase_next = pnm_hp_pkg::PH_WIDTH;
            end
            pnm_hp_pkg::PH_WIDTH, pnm_hp_pkg::PH_HEIGHT, pnm_hp_pkg::PH_MAX:
            begin
                if (eff_comment)
                begin
                    comment_next = !entry.is_lf;
                end
                else if (entry.cls == pnm_hp_pkg::CLS_DIGIT)
                begin
                    accum_next = product[DIM_BITS-1:0];
                    seen_next  = 1'b1;
                    if (overflow)
                    begin
                        emit     = 1'b1;
                        emit_bad = 1'b1;
                    end
                end
                else if (!eff_seen || eff_phase == pnm_hp_pkg::PH_WIDTH ||
                         (eff_phase == pnm_hp_pkg::PH_HEIGHT && max_field_present))
                begin
                    // Leading skip, or the terminator of width/height that
                    // runs on into the skip before the next field
                    if (eff_seen)
                    begin
                        accum_next = '0;
                        seen_next  = 1'b0;
                        if (eff_phase == pnm_hp_pkg::PH_WIDTH)
                        begin
                            width_next = eff_accum;
                            phase_next = pnm_hp_pkg::PH_HEIGHT;
                        end
                        else
                        begin
                            height_next = eff_accum;
                            phase_next  = pnm_hp_pkg::PH_MAX;
                        end
                    end
                    case (entry.cls)
                        pnm_hp_pkg::CLS_SPACE: ;
                        pnm_hp_pkg::CLS_HASH:  comment_next = 1'b1;
                        default:
                        begin
                            emit     = 1'b1;
                            emit_bad = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    // Last number ends: exactly one whitespace byte must follow
                    accum_next = '0;
                    seen_next  = 1'b0;
                    emit       = 1'b1;
                    emit_bad   = !is_space;
                    if (eff_phase == pnm_hp_pkg::PH_HEIGHT)
                    begin
                        height_next = eff_accum;
                    end
                    else
                    begin
                        max_out = eff_accum;
                    end
                end
            end
            default: ;
        endcase
        if (emit)
        begin
            phase_next = pnm_hp_pkg::PH_DONE;
        end
    end

    assign width_ext  = {{OB{1'b0}}, width_next};
    assign height_ext = {{OB{1'b0}}, height_next};
    assign max_ext    = {{OB{1'b0}}, max_out};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pnm_hp_pkg::PH_START;
            comment_reg   <= 1'b0;
            seen_reg      <= 1'b0;
            accum_reg     <= '0;
            magic_reg     <= 8'h00;
            width_reg     <= '0;
            height_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg   <= phase_next;
                comment_reg <= comment_next;
                seen_reg    <= seen_next;
                accum_reg   <= accum_next;
                magic_reg   <= magic_next;
                width_reg   <= width_next;
                height_reg  <= height_next;
            end
            if (pop && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_bad_reg    <= emit_bad;
            out_magic_reg  <= emit_bad ? 8'h00 : magic_next;
            out_width_reg  <= emit_bad ? '0 : width_ext[OB-1:0];
            out_height_reg <= emit_bad ? '0 : height_ext[OB-1:0];
            out_max_reg    <= emit_bad ? '0 : max_ext[OB-1:0];
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.magic_char   = out_magic_reg;
    assign result_out.image_width  = out_width_reg;
    assign result_out.image_height = out_height_reg;
    assign result_out.max_value    = out_max_reg;
    assign result_out.header_bad   = out_bad_reg;

endmodule

// ----- rtl/core/pnm_header_parser_top.sv -----
// Top level of the PNM header parser: APB register, front end, queue, parser.
// Depends on pnm_hp_pkg, pnm_hp_if, pnm_hp_classify, pnm_hp_queue, pnm_hp_parse.
//
// The parser takes one header byte per clock cycle, sustained, for as long as
// the result side keeps up. A result appears on result_out after the byte that
// completes or breaks the header is accepted: that byte is written into the
// queue and then parsed straight into the result register. The rate is set by
// the parser's phase machine, which retires one queued byte per cycle, unless
// the result is stalled, with a single times-ten accumulate. A QUEUE_DEPTH-entry
// FIFO sits between the byte classifier and the parser, so input bytes keep
// flowing while a result waits to be taken; item_in.ready drops only when that
// FIFO is full. After a result, bytes are dropped without output until an item
// with frame_start set begins the next header.
// The one register, max_field_present (byte address 0, reset 1), is read when
// the height field ends; write it only while the block is idle.
module pnm_header_parser_top
#(
    parameter int DIM_BITS    = pnm_hp_pkg::DIM_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = pnm_hp_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pnm_hp_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [pnm_hp_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [pnm_hp_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                                 pready,
    pnm_hp_in_if.sink                            item_in,
    pnm_hp_out_if.source                         result_out
);

    logic                    max_field_reg;
    logic                    cfg_write;
    pnm_hp_pkg::byte_entry_t front_entry;
    pnm_hp_pkg::byte_entry_t back_entry;
    logic                    push;
    logic                    pop;
    logic                    queue_full;
    logic                    queue_empty;

    // Configuration port: zero-wait writes, word index in paddr[2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite &&
                       (paddr[2] == pnm_hp_pkg::REG_MAX_FIELD);
    assign prdata    = (paddr[2] == pnm_hp_pkg::REG_MAX_FIELD) ?
                       {{(pnm_hp_pkg::CFG_DATA_BITS-1){1'b0}}, max_field_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_field_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            max_field_reg <= pwdata[0];
        end
    end

    // Front end: accept and classify while the queue has room
    assign item_in.ready = !queue_full;
    assign push          = item_in.valid && !queue_full;

    pnm_hp_classify u_classify
    (
        .data_byte   (item_in.data_byte),
        .frame_start (item_in.frame_start),
        .entry       (front_entry)
    );

    pnm_hp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (front_entry),
        .full       (queue_full),
        .pop        (pop),
        .pop_entry  (back_entry),
        .empty      (queue_empty)
    );

    // Back end: parse one queued byte per cycle unless the result is stalled
    pnm_hp_parse #(.DIM_BITS(DIM_BITS)) u_parse
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .max_field_present (max_field_reg),
        .entry             (back_entry),
        .entry_valid       (!queue_empty),
        .pop               (pop),
        .result_out        (result_out)
    );

    // An invalid header carries all-zero fields
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.header_bad) |->
            (result_out.magic_char == 8'h00 && result_out.image_width == 16'h0000 &&
             result_out.image_height == 16'h0000 && result_out.max_value == 16'h0000))
        else $error("invalid header result carries nonzero fields");

    // Bitmap headers report a zero maximum value
    a_bitmap_max: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && !result_out.header_bad && !max_field_reg) |->
            (result_out.max_value == 16'h0000))
        else $error("bitmap header reported a maximum value");

    // The queue fills only on a push
    a_full_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(queue_full) |-> $past(push))
        else $error("queue became full without a push");

    // The parser never reads an empty queue
    a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !queue_empty)
        else $error("parser popped an empty queue");

endmodule
